### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

### hdl/bpra_pkg.sv
// Package for the page run allocator: constants, codes and shared types.
// Depends on nothing.
package bpra_pkg;
	localparam int POOL_PAGES = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam int IDX_W = $clog2(POOL_PAGES);
	localparam int CNT_W = IDX_W + 1;
	localparam int WORD_W = 32;
	localparam int WORDS = POOL_PAGES / WORD_W;
	localparam int WADDR_W = $clog2(2 * WORDS);
	localparam int BIT_W = $clog2(WORD_W);
	localparam logic [11:0] ALLOC_LIMIT = 12'd3840;
	localparam logic [31:0] KERNEL_BASE_RESET = 32'hC010_0000;

	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NO_RUN = 2'd1, ST_TAKEN = 2'd2,
		ST_RANGE = 2'd3} status_t;
	typedef enum logic [1:0] {K_ALLOC = 2'd0, K_FREE = 2'd1, K_CLAIM = 2'd2,
		K_NONE = 2'd3} kind_t;
	typedef enum logic [1:0] {R_KBASE = 2'd0, R_KPAGES = 2'd1, R_UBASE = 2'd2,
		R_UPAGES = 2'd3} reg_t;
	typedef enum logic [3:0] {S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN,
		S_MARK_RD, S_MARK, S_DONE} state_t;
endpackage

### hdl/bpra_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module bpra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### hdl/bitmap_page_run_allocator.sv
// Two-pool first-fit page run allocator.
// Requests arrive on s_axis (tdata: page_count, address; tuser: kind, pool). Each
// request gives exactly one result transaction on m_axis (tdata: result_address,
// status). The four pool registers sit on an APB-style port. A request takes the
// base and page count of its pool at the edge where it is accepted.
// Both occupancy maps share one 32-bit wide RAM of 256 words, kernel words first.
// After reset a clearing pass writes one word a cycle to all 256 words. No request
// is taken meanwhile, though configuration writes are.
// A small sequencer runs one shared bit-test and word-update unit over the single
// RAM port. A claim passes through the check, mark read, mark and done states.
// A request that fails its checks, or frees zero pages, goes from check to done.
// Free reads each page and then writes it back. Allocate scans from page 0 at
// one page per cycle, with a read state before each 32-page word. It then marks
// the run page by page, each a read then a write back. Only one request is in
// flight: a new request is accepted only once the last result has been taken.
// A result waits in the output register until it is taken. A stalled receiver
// holds the sequencer in its done state, and no new request is accepted.
module bitmap_page_run_allocator import bpra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // page_count[11:0], address[43:12], zeros
	input  logic [2:0]  s_axis_tuser,  // kind[1:0], pool[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // result_address[31:0], status[33:32], zeros
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0] kbase_q, ubase_q;
	logic [12:0] kpages_q, upages_q;
	reg_t        ridx;

	// Request registers, captured when the request transaction is accepted.
	kind_t       kind_q;
	logic        pool_q;
	logic [11:0] cnt_q;
	logic [31:0] addr_q, base_q;
	logic [CNT_W-1:0] pages_q;

	// Sequencer registers.
	state_t state_q, state_d;
	logic [CNT_W-1:0] i_q;      // current page
	logic [CNT_W-1:0] run_q;    // free run length, or pages left to touch
	logic [IDX_W-1:0] idx_q;    // start page of the current free run
	logic [31:0] res_addr_q;
	status_t     status_q;

	logic [WADDR_W-1:0] ram_addr;
	logic        ram_we;
	logic [31:0] ram_wdata, ram_rdata;

	logic [31:0] off;
	logic        in_range;
	logic [19:0] off_pg;
	logic        fits;
	logic [BIT_W-1:0] bsel;
	logic [IDX_W-1:0] ipg;
	logic        cur_bit;
	logic [12:0] pk, pu;
	logic        accept;
	logic [CNT_W-1:0] run_inc;
	logic        scan_hit;
	logic        scan_last;
	logic        alloc_go;
	status_t     chk_status;
	logic [31:0] upd_word;

	assign pready = 1'b1;
	assign ridx   = reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbase_q  <= KERNEL_BASE_RESET;
			kpages_q <= '0;
			ubase_q  <= '0;
			upages_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				R_KBASE:  kbase_q  <= pwdata;
				R_KPAGES: kpages_q <= pwdata[12:0];
				R_UBASE:  ubase_q  <= pwdata;
				R_UPAGES: upages_q <= pwdata[12:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			R_KBASE:  prdata = kbase_q;
			R_KPAGES: prdata = {19'd0, kpages_q};
			R_UBASE:  prdata = ubase_q;
			R_UPAGES: prdata = {19'd0, upages_q};
			default:  prdata = '0;
		endcase
	end

	bpra_ram #(.WIDTH(WORD_W), .DEPTH(2 * WORDS)) u_map (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Address check: offset from the base, page alignment and page range.
	assign off      = addr_q - base_q;
	assign off_pg   = off[31:PAGE_SHIFT];
	assign in_range = (addr_q >= base_q) && (off[PAGE_SHIFT-1:0] == '0)
		&& ({7'd0, off_pg} < {14'd0, pages_q});
	assign fits     = ({8'd0, off_pg} + {16'd0, cnt_q}) <= {15'd0, pages_q};

	assign ipg     = i_q[IDX_W-1:0];
	assign bsel    = ipg[BIT_W-1:0];
	assign cur_bit = ram_rdata[bsel];

	// Page count registers above the map size count as a full map.
	assign pk = (kpages_q > 13'(POOL_PAGES)) ? 13'(POOL_PAGES) : kpages_q;
	assign pu = (upages_q > 13'(POOL_PAGES)) ? 13'(POOL_PAGES) : upages_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign run_inc   = run_q + 1'b1;
	assign scan_hit  = !cur_bit && (run_inc == CNT_W'(cnt_q));
	assign scan_last = (i_q + 1'b1) == pages_q;
	assign alloc_go  = (cnt_q != '0) && (cnt_q < ALLOC_LIMIT) && (pages_q != '0);

	assign ram_addr = (state_q == S_CLEAR) ? i_q[WADDR_W-1:0]
		: {pool_q, ipg[IDX_W-1:BIT_W]};

	// Status left by the check; an allocation or a claim settles its status when it marks.
	always_comb begin
		unique case (kind_q)
			K_ALLOC: chk_status = ST_NO_RUN;
			K_FREE:  chk_status = (in_range && fits) ? ST_OK : ST_RANGE;
			default: chk_status = ST_RANGE;
		endcase
	end

	// The word read back with the addressed page set, or cleared for a free.
	always_comb begin
		upd_word       = ram_rdata;
		upd_word[bsel] = (kind_q != K_FREE);
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_wdata = upd_word;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (i_q == CNT_W'(2 * WORDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: if (accept) state_d = S_CHECK;
			S_CHECK: begin
				state_d = S_DONE;
				unique case (kind_q)
					K_ALLOC: if (alloc_go) state_d = S_SCAN_RD;
					K_FREE:  if (in_range && fits && cnt_q != '0) state_d = S_MARK_RD;
					K_CLAIM: if (in_range) state_d = S_MARK_RD;
					default: ;
				endcase
			end
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: begin
				if (scan_hit) state_d = S_MARK_RD;
				else if (scan_last) state_d = S_DONE;
				else if (bsel == BIT_W'(WORD_W - 1)) state_d = S_SCAN_RD;
			end
			S_MARK_RD: state_d = S_MARK;
			S_MARK: begin
				ram_we  = 1'b1;
				state_d = (run_q == CNT_W'(1)) ? S_DONE : S_MARK_RD;
			end
			S_DONE: if (m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= K_ALLOC;
			pool_q     <= 1'b0;
			cnt_q      <= '0;
			addr_q     <= '0;
			base_q     <= '0;
			pages_q    <= '0;
			i_q        <= '0;
			run_q      <= '0;
			idx_q      <= '0;
			res_addr_q <= '0;
			status_q   <= ST_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: i_q <= i_q + 1'b1;
				S_IDLE: if (accept) begin
					kind_q  <= kind_t'(s_axis_tuser[1:0]);
					pool_q  <= s_axis_tuser[2];
					cnt_q   <= s_axis_tdata[11:0];
					addr_q  <= s_axis_tdata[43:12];
					base_q  <= s_axis_tuser[2] ? ubase_q : kbase_q;
					pages_q <= s_axis_tuser[2] ? pu : pk;
				end
				S_CHECK: begin
					res_addr_q <= '0;
					status_q   <= chk_status;
					i_q        <= (kind_q == K_ALLOC) ? '0 : CNT_W'(off_pg);
					run_q      <= (kind_q == K_FREE) ? CNT_W'(cnt_q)
						: ((kind_q == K_CLAIM) ? CNT_W'(1) : '0);
				end
				S_SCAN: begin
					// ram_rdata holds the word of page i_q.
					if (scan_hit) begin
						i_q   <= (run_q == '0) ? i_q : {1'b0, idx_q};
						idx_q <= (run_q == '0) ? ipg : idx_q;
						run_q <= CNT_W'(cnt_q);
					end else begin
						i_q <= i_q + 1'b1;
						if (cur_bit) begin
							run_q <= '0;
						end else begin
							run_q <= run_inc;
							if (run_q == '0) idx_q <= ipg;
						end
					end
				end
				S_MARK: begin
					i_q   <= i_q + 1'b1;
					run_q <= run_q - 1'b1;
					if (run_q == CNT_W'(1)) begin
						if (kind_q == K_ALLOC) begin
							status_q   <= ST_OK;
							res_addr_q <= base_q + {8'd0, idx_q, {PAGE_SHIFT{1'b0}}};
						end else if (kind_q == K_CLAIM) begin
							status_q   <= cur_bit ? ST_TAKEN : ST_OK;
							res_addr_q <= cur_bit ? '0 : addr_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = (state_q == S_DONE);
	assign m_axis_tdata  = {6'd0, status_q, res_addr_q};
endmodule

### hdl/bpra_checker.sv
// Port-level checker for the page run allocator, bound to the top level.
// Depends on bpra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bpra_checker import bpra_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	logic failed_res;
	assign failed_res = m_axis_tvalid && (status_t'(m_axis_tdata[33:32]) != ST_OK);

	// Never ready for a request while a result is pending.
	`CHK_IMPL(a_excl, m_axis_tvalid, !s_axis_tready)
	// A stalled result holds its data.
	`CHK_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// An accepted request makes the block busy.
	`CHK_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A failed request reports no address.
	`CHK_IMPL(a_fail, failed_res, m_axis_tdata[31:0] == 32'd0)
endmodule

bind bitmap_page_run_allocator bpra_checker u_chk (.*);

### dv/tb_bitmap_page_run_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-pool first-fit page run allocator.
// Depends on bpra_pkg and bitmap_page_run_allocator; needs nothing else.
module tb_bitmap_page_run_allocator import bpra_pkg::*; ();

	// Ceiling on the whole run. The slowest phase scans a 4096-page pool per
	// allocation; every other phase uses small pools.
	localparam int CYCLE_LIMIT = 3_000_000;
	// Cycles allowed for the block to settle once nothing is expected any more.
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		kind_t       kind;
		logic        pool;
		logic [11:0] cnt;
		logic [31:0] addr;
	} page_req_t;

	typedef struct packed {
		logic [31:0] addr;
		status_t     status;
	} page_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bitmap_page_run_allocator dut (.*);

	// Requests waiting to be offered, and results the predictor has worked out.
	page_req_t    pending_reqs[$];
	page_result_t expected_results[$];

	// Shadow of the configuration and of both occupancy maps (kernel is 0).
	logic [31:0] pool_base[2];
	logic [12:0] pool_pages[2];
	logic        page_used[2][POOL_PAGES];

	int  sender_idle_pct;
	int  receiver_stall_pct;
	int  hold_off_left;
	logic hold_off_start;
	bit  failed = 1'b0;
	int  cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mirrors the allocator for one accepted request and updates the shadow maps.
	function automatic page_result_t allocate_or_release(page_req_t r);
		page_result_t res;
		int unsigned  pages, run, first;
		logic [32:0]  offset;
		res.addr = '0;
		res.status = ST_RANGE;
		pages = (pool_pages[r.pool] > POOL_PAGES) ? POOL_PAGES : pool_pages[r.pool];
		// The page index is only meaningful when the address lies in the pool and
		// sits on a page boundary counted from the pool base.
		offset = {1'b0, r.addr} - {1'b0, pool_base[r.pool]};
		case (r.kind)
			K_ALLOC: begin
				res.status = ST_NO_RUN;
				if (r.cnt != 0 && r.cnt < ALLOC_LIMIT) begin
					run = 0;
					for (int i = 0; i < pages; i++) begin
						run = page_used[r.pool][i] ? 0 : run + 1;
						if (run == r.cnt) begin
							first = i + 1 - r.cnt;
							for (int j = 0; j < r.cnt; j++)
								page_used[r.pool][first + j] = 1'b1;
							res.addr = pool_base[r.pool] + (first << PAGE_SHIFT);
							res.status = ST_OK;
							break;
						end
					end
				end
			end
			K_FREE: begin
				if (!offset[32] && offset[11:0] == 0 && (offset >> PAGE_SHIFT) < pages
						&& (offset >> PAGE_SHIFT) + r.cnt <= pages) begin
					first = 32'(offset >> PAGE_SHIFT);
					for (int j = 0; j < r.cnt; j++)
						page_used[r.pool][first + j] = 1'b0;
					res.status = ST_OK;
				end
			end
			K_CLAIM: begin
				if (!offset[32] && offset[11:0] == 0 && (offset >> PAGE_SHIFT) < pages) begin
					first = 32'(offset >> PAGE_SHIFT);
					if (page_used[r.pool][first]) begin
						res.status = ST_TAKEN;
					end else begin
						page_used[r.pool][first] = 1'b1;
						res.addr = r.addr;
						res.status = ST_OK;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Sender: offers queued requests, idling at random, and predicts each result
	// at the edge where its transaction is accepted.
	always @(posedge clk or negedge arst_n) begin
		page_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(allocate_or_release({s_axis_tuser[1:0],
					s_axis_tuser[2], s_axis_tdata[11:0], s_axis_tdata[43:12]}));
			if (s_axis_tvalid && !s_axis_tready) begin
				// Held until the block takes it.
			end else if (pending_reqs.size() != 0
					&& $urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, nxt.addr, nxt.cnt};
				s_axis_tuser <= {nxt.pool, nxt.kind};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// A long receiver hold-off, counted here so that the block fills and stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_off_left <= 0;
		else if (hold_off_start)
			hold_off_left <= 600;
		else if (hold_off_left != 0)
			hold_off_left <= hold_off_left - 1;
	end

	// Receiver: checks each result transaction against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result addr=%h status=%0d", $time,
						m_axis_tdata[31:0], m_axis_tdata[33:32]);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[31:0] !== want.addr) begin
						$display("%0t: result_address expected %h actual %h", $time,
							want.addr, m_axis_tdata[31:0]);
						failed = 1'b1;
					end
					if (m_axis_tdata[33:32] !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, m_axis_tdata[33:32]);
						failed = 1'b1;
					end
				end
			end
			m_axis_tready <= (hold_off_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle; the shadow follows it.
	task automatic write_reg(reg_t index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			R_KBASE:  pool_base[0] = value;
			R_KPAGES: pool_pages[0] = value[12:0];
			R_UBASE:  pool_base[1] = value;
			default:  pool_pages[1] = value[12:0];
		endcase
	endtask

	task automatic set_pools(logic [31:0] kb, logic [12:0] kp, logic [31:0] ub,
			logic [12:0] up);
		write_reg(R_KBASE, kb);
		write_reg(R_KPAGES, {19'b0, kp});
		write_reg(R_UBASE, ub);
		write_reg(R_UPAGES, {19'b0, up});
	endtask

	task automatic queue_req(kind_t k, logic p, logic [11:0] c, logic [31:0] a);
		pending_reqs.push_back('{kind: k, pool: p, cnt: c, addr: a});
	endtask

	function automatic logic [31:0] page_address(logic p, int unsigned idx);
		return pool_base[p] + (idx << PAGE_SHIFT);
	endfunction

	// Mostly well-formed traffic with random content, plus a share of noise.
	task automatic queue_random(int n, int max_run);
		int          sel, pages, idx;
		logic        p;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			p = 1'($urandom_range(1));
			pages = (pool_pages[p] > POOL_PAGES) ? POOL_PAGES : pool_pages[p];
			idx = (pages == 0) ? 0 : $urandom_range(pages - 1);
			if (sel < 40) begin
				queue_req(K_ALLOC, p, 12'($urandom_range(1, max_run)), $urandom);
			end else if (sel < 62) begin
				queue_req(K_FREE, p, 12'($urandom_range(0, max_run)), page_address(p, idx));
			end else if (sel < 82) begin
				queue_req(K_CLAIM, p, 12'($urandom), page_address(p, idx));
			end else if (sel < 90) begin
				// Near misses: off the page grid or just outside the pool.
				queue_req(kind_t'($urandom_range(K_FREE, K_CLAIM)), p,
					12'($urandom_range(1, 4)),
					page_address(p, idx) + ($urandom_range(1) ? $urandom_range(1, 4095)
					: (pages - idx) << PAGE_SHIFT));
			end else begin
				queue_req(kind_t'($urandom_range(3)), p, 12'($urandom), $urandom);
			end
		end
	endtask

	// Lets every queued request through, then gives the block time to settle.
	// Sampled at the falling edge so that the sender's updates have landed.
	task automatic drain();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_off_start = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		pool_base[0] = KERNEL_BASE_RESET;
		pool_base[1] = '0;
		pool_pages[0] = '0;
		pool_pages[1] = '0;
		for (int p = 0; p < 2; p++)
			for (int i = 0; i < POOL_PAGES; i++)
				page_used[p][i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset configuration both pools are empty, so nothing fits.
		queue_req(K_ALLOC, 1'b0, 12'd1, '0);
		queue_req(K_CLAIM, 1'b0, '0, KERNEL_BASE_RESET);
		drain();

		// Directed: a small kernel pool and a user pool whose addresses wrap.
		set_pools(32'hC010_0000, 13'd16, 32'hFFFF_8000, 13'd16);
		queue_req(K_ALLOC, 1'b0, 12'd1, '0);
		queue_req(K_ALLOC, 1'b0, 12'd15, '0);
		queue_req(K_ALLOC, 1'b0, 12'd1, '0);           // pool full: no run
		queue_req(K_ALLOC, 1'b0, 12'd0, '0);           // zero count
		queue_req(K_ALLOC, 1'b1, ALLOC_LIMIT, '0);     // count at the limit
		queue_req(K_ALLOC, 1'b1, 12'hFFF, '0);
		queue_req(K_FREE, 1'b0, 12'd3, 32'hC010_2000);
		queue_req(K_FREE, 1'b0, 12'd3, 32'hC010_2000); // already free
		queue_req(K_FREE, 1'b0, 12'd0, 32'hC010_F000); // zero pages at the last page
		queue_req(K_FREE, 1'b0, 12'd2, 32'hC010_F000); // runs past the pool
		queue_req(K_CLAIM, 1'b0, '0, 32'hC010_3000);
		queue_req(K_CLAIM, 1'b0, '0, 32'hC010_3000);   // already taken
		queue_req(K_CLAIM, 1'b0, '0, 32'hC010_2800);   // off the page grid
		queue_req(K_CLAIM, 1'b0, '0, 32'hC00F_F000);   // below the base
		queue_req(K_CLAIM, 1'b0, '0, 32'hC011_0000);   // one page beyond
		queue_req(K_ALLOC, 1'b0, 12'd2, '0);           // no run of two: page 3 was claimed
		queue_req(K_NONE, 1'b0, 12'd1, 32'hC010_0000);
		queue_req(K_ALLOC, 1'b1, 12'd16, '0);          // run wraps past zero
		queue_req(K_FREE, 1'b1, 12'd8, 32'hFFFF_8000);
		queue_req(K_CLAIM, 1'b1, '0, 32'hFFFF_F000);
		queue_req(K_ALLOC, 1'b1, 12'd7, '0);
		queue_req(K_FREE, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
		drain();

		set_pools(32'h0000_0000, 13'd64, 32'h1234_5000, 13'd200);
		queue_random(150, 12);
		drain();

		sender_idle_pct = 49;
		set_pools(32'h8000_0000, 13'd100, 32'hFFF0_0000, 13'd256);
		queue_random(150, 20);
		drain();

		// Oversized pool registers clamp to the full map; only a few requests
		// here since each allocation may scan all 4096 pages.
		sender_idle_pct = 0;
		set_pools(32'hFFFF_F000, 13'h1FFF, 32'h0000_1000, 13'd4096);
		queue_random(30, 3000);
		drain();

		receiver_stall_pct = 49;
		set_pools(32'h4000_0000, 13'd32, 32'h0000_0000, 13'd1);
		queue_random(150, 8);
		@(posedge clk);
		hold_off_start <= 1'b1;
		@(posedge clk);
		hold_off_start <= 1'b0;
		drain();

		sender_idle_pct = 17;
		receiver_stall_pct = 17;
		set_pools(32'hABCD_E000, 13'd128, 32'h5555_5000, 13'd8);
		queue_random(150, 16);
		drain();

		if (!failed)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
